// ===== src/rss_pkg.sv =====
// shared types and constants of the record stack with search
package rss_pkg;

	localparam int FieldW = 16;
	localparam int OutCountW = 7;

	// operation codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_FIND = 3'd2;
	localparam logic [2:0] OP_SET  = 3'd3;
	localparam logic [2:0] OP_MIN  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [FieldW-1:0] id;
		logic [FieldW-1:0] diameter;
		logic [FieldW-1:0] capacity;
	} rec_t;

	// command to every cell of the chain
	typedef struct packed {
		logic push;      // take record from the neighbor above (toward top)
		logic shift_up;  // take record from the neighbor below (toward bottom)
	} cell_cmd_t;

endpackage

// ===== src/rss_in_if.sv =====
// request channel of the record stack
interface rss_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] id;
	logic [15:0] diameter;
	logic [15:0] capacity;

	modport source (output valid, op, id, diameter, capacity, input ready);
	modport sink   (input valid, op, id, diameter, capacity, output ready);
endinterface

// ===== src/rss_out_if.sv =====
// response channel of the record stack
interface rss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] rec_id;
	logic [15:0] rec_diameter;
	logic [15:0] rec_capacity;
	logic [6:0]  entry_count;

	modport source (output valid, status, rec_id, rec_diameter, rec_capacity, entry_count,
		input ready);
	modport sink   (input valid, status, rec_id, rec_diameter, rec_capacity, entry_count,
		output ready);
endinterface

// ===== src/rss_cell.sv =====
// one stack slot: holds a record and moves it to either neighbor
module rss_cell (
	input  logic               clk,
	input  rss_pkg::cell_cmd_t cmd,
	input  rss_pkg::rec_t      above,
	input  rss_pkg::rec_t      below,
	output rss_pkg::rec_t      rec
);

	rss_pkg::rec_t rec_q;

	// slot register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			rec_q <= above;
		end else if (cmd.shift_up) begin
			rec_q <= below;
		end
	end

	assign rec = rec_q;

endmodule

// ===== src/record_stack_with_search_core.sv =====
// top level of the record stack with id and minimum-diameter search
// Bounded LIFO of DEPTH records held in a chain of cells, cell 0 being the top.
// Push and pop shift the whole chain by one place and answer in the cycle after the
// request; the next request is taken once that response has been taken. Find by id,
// set capacity by id and minimum-diameter search rotate the chain once around, so
// every record passes the top cell, which does the compare: such a request answers after
// the scan and finish states, or as push and pop do on an empty stack. Set capacity
// rewrites the matching record as it passes, and the rotation leaves the order intact.
// entry_count reports the number of records held, cut to its 7 bits.
module record_stack_with_search_core #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	rss_in_if.sink    req,
	rss_out_if.source rsp
);

	localparam int CntW  = $clog2(DEPTH + 1);
	localparam int StepW = $clog2(DEPTH);
	localparam logic [CntW-1:0] Full = CntW'(DEPTH);
	localparam logic [StepW-1:0] LastStep = StepW'(DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CntW-1:0]  count_q;
	logic [StepW-1:0] step_q;
	logic [2:0]       op_q;
	logic [15:0]      key_q;
	logic [15:0]      cap_q;
	logic             found_q;
	rss_pkg::rec_t    best_q;

	logic             out_valid_q;
	logic [1:0]       out_status_q;
	rss_pkg::rec_t    out_rec_q;
	logic [6:0]       out_count_q;

	rss_pkg::rec_t     cells [DEPTH];
	rss_pkg::rec_t     new_rec;
	rss_pkg::rec_t     head;
	rss_pkg::rec_t     feed;
	rss_pkg::cell_cmd_t cmd;
	logic              accept;
	logic              in_range;
	logic              hit;
	logic              do_push;
	logic              do_pop;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept    = req.valid && req.ready;
	assign new_rec   = '{id: req.id, diameter: req.diameter, capacity: req.capacity};
	assign head      = cells[0];

	// compare at the top cell while scanning by id
	assign in_range = CntW'(step_q) < count_q;
	assign hit      = (state_q == S_SCAN) && (op_q != rss_pkg::OP_MIN) && in_range &&
		!found_q && (head.id == key_q);

	// record fed back into the bottom of the chain during rotation
	always_comb begin
		feed = head;
		if (hit && (op_q == rss_pkg::OP_SET)) begin
			feed.capacity = cap_q;
		end
	end

	// chain command
	assign do_push = accept && (req.op == rss_pkg::OP_PUSH) && (count_q < Full);
	assign do_pop  = accept && (req.op == rss_pkg::OP_POP) && (count_q != '0);
	assign cmd.push     = do_push;
	assign cmd.shift_up = do_pop || (state_q == S_SCAN);

	// the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rss_pkg::rec_t above;
		rss_pkg::rec_t below;
		if (i == 0) begin : g_top
			assign above = new_rec;
		end else begin : g_mid_a
			assign above = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = feed;
		end else begin : g_mid_b
			assign below = cells[i+1];
		end
		rss_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.above (above),
			.below (below),
			.rec   (cells[i])
		);
	end

	// scan bookkeeping registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			key_q   <= req.id;
			cap_q   <= req.capacity;
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				best_q <= feed;
			end else if ((op_q == rss_pkg::OP_MIN) && in_range &&
					((step_q == '0) || (head.diameter < best_q.diameter))) begin
				best_q <= head;
			end
		end
	end

	// control: state, count, step, match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					step_q  <= '0;
					found_q <= 1'b0;
					if (accept && (count_q != '0) && ((req.op == rss_pkg::OP_FIND) ||
							(req.op == rss_pkg::OP_SET) || (req.op == rss_pkg::OP_MIN))) begin
						state_q <= S_SCAN;
					end
					if (do_push) begin
						count_q <= count_q + 1'b1;
					end else if (do_pop) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					step_q <= step_q + 1'b1;
					if (step_q == LastStep) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !((count_q != '0) && ((req.op == rss_pkg::OP_FIND) ||
				(req.op == rss_pkg::OP_SET) || (req.op == rss_pkg::OP_MIN)))) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_FIN) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= rss_pkg::ST_OK;
			out_rec_q    <= '0;
			out_count_q  <= 7'(count_q);
			unique case (req.op)
				rss_pkg::OP_PUSH: begin
					if (count_q < Full) begin
						out_rec_q   <= new_rec;
						out_count_q <= 7'(count_q + 1'b1);
					end else begin
						out_status_q <= rss_pkg::ST_FULL;
					end
				end
				rss_pkg::OP_POP: begin
					if (count_q != '0) begin
						out_rec_q   <= head;
						out_count_q <= 7'(count_q - 1'b1);
					end else begin
						out_status_q <= rss_pkg::ST_EMPTY;
					end
				end
				rss_pkg::OP_FIND, rss_pkg::OP_SET: begin
					out_status_q <= rss_pkg::ST_NOTFOUND;
				end
				rss_pkg::OP_MIN: begin
					out_status_q <= rss_pkg::ST_EMPTY;
				end
				default: begin
					out_status_q <= rss_pkg::ST_OK;
				end
			endcase
		end else if (state_q == S_FIN) begin
			out_count_q <= 7'(count_q);
			if ((op_q == rss_pkg::OP_MIN) || found_q) begin
				out_status_q <= rss_pkg::ST_OK;
				out_rec_q    <= best_q;
			end else begin
				out_status_q <= rss_pkg::ST_NOTFOUND;
				out_rec_q    <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.rec_id       = out_rec_q.id;
	assign rsp.rec_diameter = out_rec_q.diameter;
	assign rsp.rec_capacity = out_rec_q.capacity;
	assign rsp.entry_count  = out_count_q;

endmodule

// ===== sim/tb_record_stack_with_search_core.sv =====
// testbench for the record stack with id and minimum-diameter search
`timescale 1ns / 1ps

module tb_record_stack_with_search_core;

	localparam int DEPTH = 64;
	localparam int PHASE_ITEMS = 540;
	localparam int MAX_REPORTS = 10;

	// op codes the block treats as no-ops
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [1:0]    status;
		rss_pkg::rec_t rec;
		logic [6:0]    count;
	} reply_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_EVEN} mix_t;

	logic clk;
	logic arst_n;

	rss_in_if  req_if ();
	rss_out_if rsp_if ();

	record_stack_with_search_core #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow copy of the stack, slot 0 at the bottom
	rss_pkg::rec_t model_recs [DEPTH];
	int            model_depth;
	reply_t        pending_replies [$];
	logic [15:0]   key_pool [8];

	int src_idle_pct;
	int snk_idle_pct;
	int mismatches;
	int peak_depth;
	int op_count [8];
	int status_count [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#15ms;
		$display("tb_record_stack_with_search_core: FAIL");
		$finish;
	end

	// applies one request to the shadow stack and returns the reply it should give
	function automatic reply_t stack_model_apply(input logic [2:0] op,
		input rss_pkg::rec_t rec);
		reply_t r;
		int     slot;
		r = '0;
		slot = -1;
		case (op)
		rss_pkg::OP_PUSH: begin
			if (model_depth >= DEPTH) begin
				r.status = rss_pkg::ST_FULL;
			end else begin
				model_recs[model_depth] = rec;
				model_depth++;
				r.rec = rec;
			end
		end
		rss_pkg::OP_POP: begin
			if (model_depth == 0) begin
				r.status = rss_pkg::ST_EMPTY;
			end else begin
				model_depth--;
				r.rec = model_recs[model_depth];
			end
		end
		rss_pkg::OP_FIND, rss_pkg::OP_SET: begin
			for (int n = model_depth - 1; n >= 0 && slot < 0; n--)
				if (model_recs[n].id == rec.id)
					slot = n;
			if (slot < 0) begin
				r.status = rss_pkg::ST_NOTFOUND;
			end else begin
				if (op == rss_pkg::OP_SET)
					model_recs[slot].capacity = rec.capacity;
				r.rec = model_recs[slot];
			end
		end
		rss_pkg::OP_MIN: begin
			if (model_depth == 0) begin
				r.status = rss_pkg::ST_EMPTY;
			end else begin
				slot = model_depth - 1;
				// strict compare keeps the record nearest the top on a tie
				for (int n = model_depth - 2; n >= 0; n--)
					if (model_recs[n].diameter < model_recs[slot].diameter)
						slot = n;
				r.rec = model_recs[slot];
			end
		end
		default: ;
		endcase
		r.count = 7'(model_depth);
		return r;
	endfunction

	// mostly ids from a small pool so that searches hit and ids repeat
	function automatic logic [15:0] random_key();
		if ($urandom_range(99) < 75)
			return key_pool[$urandom_range(7)];
		return 16'($urandom);
	endfunction

	// small diameters half the time so the min search sees ties
	function automatic logic [15:0] random_diameter();
		if ($urandom_range(1) == 0)
			return 16'($urandom_range(7));
		return 16'($urandom);
	endfunction

	// drive one request, wait for its handshake and record the reply it should give
	task automatic send_request(input logic [2:0] op, input logic [15:0] id,
		input logic [15:0] diameter, input logic [15:0] capacity);
		reply_t want;
		if ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		req_if.valid    <= 1'b1;
		req_if.op       <= op;
		req_if.id       <= id;
		req_if.diameter <= diameter;
		req_if.capacity <= capacity;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		want = stack_model_apply(op, rss_pkg::rec_t'{id, diameter, capacity});
		pending_replies.push_back(want);
		op_count[op]++;
		if (model_depth > peak_depth)
			peak_depth = model_depth;
	endtask

	// hold off the sender until every reply is in
	task automatic wait_for_replies();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	// empty stack: pop, min, find, set and the spare op codes
	task automatic test_empty_stack();
		send_request(rss_pkg::OP_POP, 16'h0000, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_MIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(rss_pkg::OP_FIND, 16'h0000, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_SET, 16'hFFFF, 16'h0000, 16'hFFFF);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			send_request(3'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	// field extremes, duplicate ids, capacity update, misses and a diameter tie
	task automatic test_record_ops();
		send_request(rss_pkg::OP_PUSH, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_request(rss_pkg::OP_PUSH, 16'h0000, 16'hFFFF, 16'h0000);
		send_request(rss_pkg::OP_PUSH, 16'h1234, 16'h0000, 16'h1111);
		send_request(rss_pkg::OP_PUSH, 16'hFFFF, 16'h8000, 16'h2222);
		send_request(rss_pkg::OP_FIND, 16'hFFFF, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_SET, 16'hFFFF, 16'h0000, 16'hABCD);
		send_request(rss_pkg::OP_FIND, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_request(rss_pkg::OP_SET, 16'h0000, 16'h0000, 16'hFFFF);
		send_request(rss_pkg::OP_FIND, 16'h5555, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_SET, 16'h5555, 16'h0000, 16'h7777);
		send_request(rss_pkg::OP_MIN, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_SPARE_LO, 16'h1234, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_POP, 16'h0000, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_FIND, 16'hFFFF, 16'h0000, 16'h0000);
		send_request(rss_pkg::OP_MIN, 16'h0000, 16'h0000, 16'h0000);
		for (int k = 0; k < 4; k++)
			send_request(rss_pkg::OP_POP, 16'h0000, 16'h0000, 16'h0000);
	endtask

	// fill to the top, push past it, search a full stack, then drain past empty
	task automatic test_full_stack();
		while (model_depth < DEPTH)
			send_request(rss_pkg::OP_PUSH, random_key(), random_diameter(), 16'($urandom));
		send_request(rss_pkg::OP_PUSH, random_key(), random_diameter(), 16'($urandom));
		send_request(rss_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(rss_pkg::OP_MIN, random_key(), 16'($urandom), 16'($urandom));
		send_request(rss_pkg::OP_FIND, model_recs[0].id, 16'($urandom), 16'($urandom));
		send_request(rss_pkg::OP_SET, model_recs[0].id, 16'($urandom), 16'($urandom));
		send_request(rss_pkg::OP_SET, random_key(), 16'($urandom), 16'($urandom));
		while (model_depth > 0)
			send_request(rss_pkg::OP_POP, random_key(), 16'($urandom), 16'($urandom));
		send_request(rss_pkg::OP_POP, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// random bursts that lean toward filling, draining, searching or neither
	task automatic test_random_mix(input int n_items);
		mix_t       mix;
		int         push_pct;
		int         pop_pct;
		int         pick;
		int         burst;
		int         sent;
		logic [2:0] op;
		sent = 0;
		push_pct = 0;
		pop_pct = 0;
		while (sent < n_items) begin
			mix = mix_t'($urandom_range(3));
			case (mix)
			MIX_FILL: begin
				push_pct = 65;
				pop_pct = 10;
			end
			MIX_DRAIN: begin
				push_pct = 10;
				pop_pct = 65;
			end
			MIX_SEARCH: begin
				push_pct = 20;
				pop_pct = 15;
			end
			default: begin
				push_pct = 35;
				pop_pct = 30;
			end
			endcase
			burst = $urandom_range(16, 80);
			for (int k = 0; k < burst && sent < n_items; k++) begin
				pick = $urandom_range(99);
				if (pick < push_pct) begin
					op = rss_pkg::OP_PUSH;
				end else if (pick < push_pct + pop_pct) begin
					op = rss_pkg::OP_POP;
				end else if (pick >= 97) begin
					op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				end else begin
					case (pick % 3)
					0:       op = rss_pkg::OP_FIND;
					1:       op = rss_pkg::OP_SET;
					default: op = rss_pkg::OP_MIN;
					endcase
				end
				send_request(op, random_key(), random_diameter(), 16'($urandom));
				sent++;
			end
		end
	endtask

	// reply checker and receiver stalls
	always @(posedge clk) begin : reply_check
		reply_t got;
		reply_t want;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			got = {rsp_if.status, rsp_if.rec_id, rsp_if.rec_diameter, rsp_if.rec_capacity,
				rsp_if.entry_count};
			status_count[got.status]++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected reply status %0d id %h dia %h cap %h count %0d",
						$realtime, got.status, got.rec.id, got.rec.diameter,
						got.rec.capacity, got.count);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: reply mismatch", $realtime);
						$display("  status   exp %0d got %0d", want.status, got.status);
						$display("  id       exp %h got %h", want.rec.id, got.rec.id);
						$display("  diameter exp %h got %h", want.rec.diameter,
							got.rec.diameter);
						$display("  capacity exp %h got %h", want.rec.capacity,
							got.rec.capacity);
						$display("  count    exp %0d got %0d", want.count, got.count);
					end
				end
			end
		end
		rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// test sequence
	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = rss_pkg::OP_PUSH;
		req_if.id = '0;
		req_if.diameter = '0;
		req_if.capacity = '0;
		rsp_if.ready = 1'b0;
		model_depth = 0;
		mismatches = 0;
		peak_depth = 0;
		foreach (op_count[i]) op_count[i] = 0;
		foreach (status_count[i]) status_count[i] = 0;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int k = 2; k < 8; k++)
			key_pool[k] = 16'($urandom);
		src_idle_pct = 17;
		snk_idle_pct = 79;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles rarely, receiver stalls often
		test_empty_stack();
		test_record_ops();
		test_full_stack();
		test_random_mix(PHASE_ITEMS);
		wait_for_replies();

		// sender idles often, receiver stalls rarely
		src_idle_pct = 79;
		snk_idle_pct = 17;
		test_full_stack();
		test_random_mix(PHASE_ITEMS);
		wait_for_replies();

		// back to back on both sides
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_full_stack();
		test_random_mix(PHASE_ITEMS);
		wait_for_replies();

		// catch any stray reply after the last one
		repeat (DEPTH + 4) @(posedge clk);

		$display("requests: push %0d, pop %0d, find %0d, set %0d, min %0d, spare %0d",
			op_count[rss_pkg::OP_PUSH], op_count[rss_pkg::OP_POP],
			op_count[rss_pkg::OP_FIND], op_count[rss_pkg::OP_SET],
			op_count[rss_pkg::OP_MIN],
			op_count[OP_SPARE_LO] + op_count[OP_SPARE_LO + 3'd1] + op_count[OP_SPARE_HI]);
		$display("replies: ok %0d, empty %0d, not found %0d, full %0d; peak depth %0d",
			status_count[rss_pkg::ST_OK], status_count[rss_pkg::ST_EMPTY],
			status_count[rss_pkg::ST_NOTFOUND], status_count[rss_pkg::ST_FULL],
			peak_depth);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("tb_record_stack_with_search_core: PASS");
		end else begin
			$display("tb_record_stack_with_search_core: FAIL");
		end
		$finish;
	end

endmodule
